[design/wdi_pkg.sv]
// Package for the windowed drift index: beat types, register indexes,
// widths and reset values shared by the cell, scaler and top level.
// No dependencies.
`default_nettype none

package wdi_pkg;

  // Default window lengths in half-hour samples
  localparam int SHORT_SAMPLES_DEF = 12;
  localparam int LONG_SAMPLES_DEF  = 48;

  localparam int SAMPLE_W = 24;
  // Sums of up to 256 signed 24 bit samples stay within 33 bits signed
  localparam int SUM_W    = 33;
  localparam int GAIN_W   = 32;
  localparam int OFFSET_W = 24;
  localparam int CAP_W    = 16;
  localparam int MINS_W   = 4;
  localparam int MINL_W   = 6;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_DRIFT_GAIN      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DRIFT_OFFSET    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CAP_SHORT       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CAP_LONG        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_COUNT_SHORT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_COUNT_LONG  = 3'd5;

  // Register reset values
  localparam logic [GAIN_W-1:0]   GAIN_RST      = 32'd2188590;
  localparam logic [OFFSET_W-1:0] OFFSET_RST    = 24'd0;
  localparam logic [CAP_W-1:0]    CAP_SHORT_RST = 16'd7680;
  localparam logic [CAP_W-1:0]    CAP_LONG_RST  = 16'd30720;
  localparam logic [MINS_W-1:0]   MINS_RST      = 4'd9;
  localparam logic [MINL_W-1:0]   MINL_RST      = 6'd36;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       sample_ok;
  } in_beat_t;

  typedef struct packed {
    logic [CAP_W-1:0] short_index;
    logic             short_valid;
    logic [CAP_W-1:0] long_index;
    logic             long_valid;
  } out_beat_t;

  // Stage load strobes of the scaling pipeline
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } wdi_adv_t;

endpackage

`default_nettype wire

[design/wdi_cell.sv]
// One window cell: holds a sample and its present mark, hands both on.
// Depends on wdi_pkg.
`default_nettype none

module wdi_cell (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                shift,
  input  wire logic signed [wdi_pkg::SAMPLE_W-1:0] d_in,
  input  wire logic                                mark_in,
  output      logic signed [wdi_pkg::SAMPLE_W-1:0] d_out,
  output      logic                                mark_out
);

  // sample value needs no reset: it is only read when its mark is set
  always_ff @(posedge clk) begin
    if (shift) begin
      d_out <= d_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mark_out <= 1'b0;
    end else if (shift) begin
      mark_out <= mark_in;
    end
  end

endmodule

`default_nettype wire

[design/wdi_scale.sv]
// Three stage scaler for one window: offset and range check, Q16.16
// multiply, saturation into the index register. Depends on wdi_pkg.
`default_nettype none

module wdi_scale (
  input  wire logic                                clk,
  input  wire wdi_pkg::wdi_adv_t                   adv,
  input  wire logic signed [wdi_pkg::SUM_W-1:0]    sum,
  input  wire logic                                enough,
  input  wire logic signed [wdi_pkg::OFFSET_W-1:0] offset,
  input  wire logic        [wdi_pkg::GAIN_W-1:0]   gain,
  input  wire logic        [wdi_pkg::CAP_W-1:0]    cap,
  output      logic        [wdi_pkg::CAP_W-1:0]    index,
  output      logic                                index_ok
);

  localparam int DIFF_W = wdi_pkg::SUM_W + 1;
  localparam int PROD_W = 2 * wdi_pkg::GAIN_W;

  logic signed [DIFF_W-1:0] diff;
  logic                     pos;

  // stage 1
  logic                         ok1;
  logic                         pos1;
  logic                         big1;
  logic [wdi_pkg::GAIN_W-1:0]   d1;
  // stage 2
  logic                         ok2;
  logic                         pos2;
  logic                         big2;
  logic [PROD_W-1:0]            prod2;

  logic                         over;
  logic [wdi_pkg::CAP_W-1:0]    index_next;

  assign diff = DIFF_W'(sum) - DIFF_W'(offset);
  assign pos  = !diff[DIFF_W-1] && (|diff);

  always_ff @(posedge clk) begin
    if (adv.s1) begin
      ok1  <= enough;
      pos1 <= pos;
      big1 <= pos && (|diff[DIFF_W-2:wdi_pkg::GAIN_W]);
      d1   <= diff[wdi_pkg::GAIN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s2) begin
      ok2   <= ok1;
      pos2  <= pos1;
      big2  <= big1;
      prod2 <= PROD_W'(d1) * PROD_W'(gain);
    end
  end

  // drop the 16 fraction bits, clamp at the cap
  assign over = (|prod2[PROD_W-1:32]) || (prod2[31:16] > cap);

  always_comb begin
    if (!ok2 || !pos2) begin
      index_next = '0;
    end else if (big2 || over) begin
      index_next = cap;
    end else begin
      index_next = prod2[31:16];
    end
  end

  always_ff @(posedge clk) begin
    if (adv.s3) begin
      index    <= index_next;
      index_ok <= ok2;
    end
  end

endmodule

`default_nettype wire

[design/windowed_drift_index.sv]
// Windowed drift index top level: window cell chain, running sums and
// counts, two scalers and the beat handshake. Depends on wdi_pkg, wdi_cell, wdi_scale.
//
// Use: each input beat carries one half-hour flux sample and its present
// flag. The sample enters a chain of LONG_SAMPLES cells; running sums and
// counts of present samples over the newest SHORT_SAMPLES and over the whole
// chain update in the same cycle from the entering and leaving samples.
// Every input beat yields exactly one output beat with both indexes and
// their valid flags.
// Throughput: one beat per cycle while in_stall is low. Steps: the sums
// update at the accepting edge, then offset and range check, 32 x 32
// multiply and saturation into the output register follow; the
// multiplier stage sets the clock.
// Stall: each pipeline stage holds its beat only while the stage after it
// is full and held, so bubbles close up and a new beat is taken while a
// finished beat still waits at the output. in_stall rises only once all
// four stages are full behind a stalled output.
// Reset: synchronous; clears all present marks, sums and counts, empties the
// pipeline and loads the register defaults. Configuration writes take effect
// at once. The user makes them only while the block is idle; no check enforces it.
`default_nettype none

module windowed_drift_index #(
  parameter int SHORT_SAMPLES = wdi_pkg::SHORT_SAMPLES_DEF,
  parameter int LONG_SAMPLES  = wdi_pkg::LONG_SAMPLES_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output      logic                               in_stall,
  input  wire wdi_pkg::in_beat_t                  in_data,
  output      logic                               out_valid,
  input  wire logic                               out_stall,
  output      wdi_pkg::out_beat_t                 out_data,
  input  wire logic                               cfg_write,
  input  wire logic [wdi_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [wdi_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // short window never longer than the chain
  localparam int SHORT_LEN = (SHORT_SAMPLES < LONG_SAMPLES) ? SHORT_SAMPLES : LONG_SAMPLES;
  localparam int SC_W      = $clog2(SHORT_LEN + 1);
  localparam int LC_W      = $clog2(LONG_SAMPLES + 1);

  // Configuration registers
  logic        [wdi_pkg::GAIN_W-1:0]   drift_gain;
  logic signed [wdi_pkg::OFFSET_W-1:0] drift_offset;
  logic        [wdi_pkg::CAP_W-1:0]    cap_short;
  logic        [wdi_pkg::CAP_W-1:0]    cap_long;
  logic        [wdi_pkg::MINS_W-1:0]   min_count_short;
  logic        [wdi_pkg::MINL_W-1:0]   min_count_long;

  always_ff @(posedge clk) begin
    if (rst) begin
      drift_gain      <= wdi_pkg::GAIN_RST;
      drift_offset    <= wdi_pkg::OFFSET_RST;
      cap_short       <= wdi_pkg::CAP_SHORT_RST;
      cap_long        <= wdi_pkg::CAP_LONG_RST;
      min_count_short <= wdi_pkg::MINS_RST;
      min_count_long  <= wdi_pkg::MINL_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        wdi_pkg::REG_DRIFT_GAIN:      drift_gain      <= cfg_data;
        wdi_pkg::REG_DRIFT_OFFSET:    drift_offset    <= cfg_data[wdi_pkg::OFFSET_W-1:0];
        wdi_pkg::REG_CAP_SHORT:       cap_short       <= cfg_data[wdi_pkg::CAP_W-1:0];
        wdi_pkg::REG_CAP_LONG:        cap_long        <= cfg_data[wdi_pkg::CAP_W-1:0];
        wdi_pkg::REG_MIN_COUNT_SHORT: min_count_short <= cfg_data[wdi_pkg::MINS_W-1:0];
        wdi_pkg::REG_MIN_COUNT_LONG:  min_count_long  <= cfg_data[wdi_pkg::MINL_W-1:0];
        default: ; // unused indexes: drop the write
      endcase
    end
  end

  // Pipeline control. fresh marks sums just updated and not yet taken by
  // the first scaler stage; v1 and v2 follow the scaler stages.
  logic              fresh;
  logic              v1;
  logic              v2;
  logic              accept;
  wdi_pkg::wdi_adv_t adv;

  always_comb begin
    adv.s3 = !out_valid || !out_stall;
    adv.s2 = !v2 || adv.s3;
    adv.s1 = !v1 || adv.s2;
  end

  assign in_stall = fresh && !adv.s1;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      fresh     <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        fresh <= 1'b1;
      end else if (adv.s1) begin
        fresh <= 1'b0;
      end
      if (adv.s1) begin
        v1 <= fresh;
      end
      if (adv.s2) begin
        v2 <= v1;
      end
      if (adv.s3) begin
        out_valid <= v2;
      end
    end
  end

  // Window cell chain, newest sample in cell 0; advance on every accept
  logic signed [wdi_pkg::SAMPLE_W-1:0] cell_d    [LONG_SAMPLES];
  logic        [LONG_SAMPLES-1:0]      cell_mark;
  logic signed [wdi_pkg::SAMPLE_W-1:0] head_d;

  // missing samples enter as zero
  assign head_d = in_data.sample_ok ? in_data.sample : '0;

  for (genvar i = 0; i < LONG_SAMPLES; i++) begin : g_cell
    if (i == 0) begin : g_head
      wdi_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .shift    (accept),
        .d_in     (head_d),
        .mark_in  (in_data.sample_ok),
        .d_out    (cell_d[i]),
        .mark_out (cell_mark[i])
      );
    end else begin : g_body
      wdi_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .shift    (accept),
        .d_in     (cell_d[i-1]),
        .mark_in  (cell_mark[i-1]),
        .d_out    (cell_d[i]),
        .mark_out (cell_mark[i])
      );
    end
  end

  // Running sums and counts
  logic signed [wdi_pkg::SUM_W-1:0] short_sum;
  logic signed [wdi_pkg::SUM_W-1:0] long_sum;
  logic        [SC_W-1:0]           short_count;
  logic        [LC_W-1:0]           long_count;
  logic signed [wdi_pkg::SUM_W-1:0] enter_v;
  logic signed [wdi_pkg::SUM_W-1:0] leave_s;
  logic signed [wdi_pkg::SUM_W-1:0] leave_l;
  logic                             leave_s_ok;
  logic                             leave_l_ok;
  logic signed [wdi_pkg::SUM_W-1:0] short_sum_next;
  logic signed [wdi_pkg::SUM_W-1:0] long_sum_next;
  logic        [SC_W-1:0]           short_count_next;
  logic        [LC_W-1:0]           long_count_next;

  assign leave_s_ok = cell_mark[SHORT_LEN-1];
  assign leave_l_ok = cell_mark[LONG_SAMPLES-1];

  always_comb begin
    enter_v = in_data.sample_ok ? wdi_pkg::SUM_W'(in_data.sample) : '0;
    leave_s = leave_s_ok ? wdi_pkg::SUM_W'(cell_d[SHORT_LEN-1]) : '0;
    leave_l = leave_l_ok ? wdi_pkg::SUM_W'(cell_d[LONG_SAMPLES-1]) : '0;
    short_sum_next   = short_sum - leave_s + enter_v;
    long_sum_next    = long_sum - leave_l + enter_v;
    short_count_next = short_count - SC_W'(leave_s_ok) + SC_W'(in_data.sample_ok);
    long_count_next  = long_count - LC_W'(leave_l_ok) + LC_W'(in_data.sample_ok);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      short_sum   <= '0;
      long_sum    <= '0;
      short_count <= '0;
      long_count  <= '0;
    end else if (accept) begin
      short_sum   <= short_sum_next;
      long_sum    <= long_sum_next;
      short_count <= short_count_next;
      long_count  <= long_count_next;
    end
  end

  // Thresholds: the count must be strictly above the minimum
  logic short_enough;
  logic long_enough;

  assign short_enough = 32'(short_count) > 32'(min_count_short);
  assign long_enough  = 32'(long_count) > 32'(min_count_long);

  // Scalers, one per window
  logic [wdi_pkg::CAP_W-1:0] short_index;
  logic [wdi_pkg::CAP_W-1:0] long_index;
  logic                      short_ok;
  logic                      long_ok;

  wdi_scale u_scale_short (
    .clk      (clk),
    .adv      (adv),
    .sum      (short_sum),
    .enough   (short_enough),
    .offset   (drift_offset),
    .gain     (drift_gain),
    .cap      (cap_short),
    .index    (short_index),
    .index_ok (short_ok)
  );

  wdi_scale u_scale_long (
    .clk      (clk),
    .adv      (adv),
    .sum      (long_sum),
    .enough   (long_enough),
    .offset   (drift_offset),
    .gain     (drift_gain),
    .cap      (cap_long),
    .index    (long_index),
    .index_ok (long_ok)
  );

  always_comb begin
    out_data.short_index = short_index;
    out_data.short_valid = short_ok;
    out_data.long_index  = long_index;
    out_data.long_valid  = long_ok;
  end

  // Checks
  a_long_count_marks : assert property (@(posedge clk) disable iff (rst)
    32'(long_count) == 32'($countones(cell_mark)))
    else $error("long count out of step with the window marks");

  a_short_in_long : assert property (@(posedge clk) disable iff (rst)
    32'(short_count) <= 32'(long_count))
    else $error("short count above long count");

  a_short_zero : assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.short_valid) |-> (out_data.short_index == '0))
    else $error("invalid short index not zero");

  a_long_zero : assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.long_valid) |-> (out_data.long_index == '0))
    else $error("invalid long index not zero");

  a_no_accept_full : assert property (@(posedge clk) disable iff (rst)
    (fresh && v1 && v2 && out_valid && out_stall) |-> in_stall)
    else $error("beat taken with the pipeline full");

endmodule

`default_nettype wire

[tb/sv/wdi_checker.sv]
`timescale 1ns / 100ps
// Scoreboard for the windowed drift index: watches both beat channels and the
// register port, predicts each output beat and compares it field by field.
// Depends on wdi_pkg.

module wdi_checker
  import wdi_pkg::*;
#(
  parameter int SHORT_SAMPLES = SHORT_SAMPLES_DEF,
  parameter int LONG_SAMPLES  = LONG_SAMPLES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  in_beat_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  out_beat_t             out_data,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    pending,
  output int                    mismatches
);

  localparam int SIX_LEN = (SHORT_SAMPLES < LONG_SAMPLES) ? SHORT_SAMPLES : LONG_SAMPLES;

  // Register copies
  logic [GAIN_W-1:0]          gain_q16;
  logic signed [OFFSET_W-1:0] flux_offset;
  logic [CAP_W-1:0]           cap6, cap24;
  logic [MINS_W-1:0]          min6;
  logic [MINL_W-1:0]          min24;

  // Window state, newest sample at index 0
  logic signed [SAMPLE_W-1:0] flux_hist [LONG_SAMPLES];
  logic                       present [LONG_SAMPLES];
  logic signed [SUM_W-1:0]    six_sum, day_sum;
  int                         cnt6, cnt24;

  out_beat_t depth_q [$];

  function automatic logic [CAP_W-1:0] depth_from_flux(logic signed [SUM_W-1:0] total,
                                                       logic [CAP_W-1:0] cap);
    logic signed [SUM_W+1:0] excess;
    logic [63:0]             scaled;
    excess = total - flux_offset;
    if (excess[SUM_W+1] || excess == 0) return '0;
    if (|excess[SUM_W:32]) return cap;
    scaled = (64'(excess[31:0]) * 64'(gain_q16)) >> 16;
    if (scaled > 64'(cap)) return cap;
    return scaled[CAP_W-1:0];
  endfunction

  // Shift one sample in, update the running sums and work out both indexes
  function automatic out_beat_t advance_window(in_beat_t b);
    out_beat_t r;
    logic      v6, v24;
    if (present[LONG_SAMPLES-1]) begin
      day_sum = day_sum - flux_hist[LONG_SAMPLES-1];
      cnt24--;
    end
    if (present[SIX_LEN-1]) begin
      six_sum = six_sum - flux_hist[SIX_LEN-1];
      cnt6--;
    end
    for (int i = LONG_SAMPLES - 1; i > 0; i--) begin
      flux_hist[i] = flux_hist[i-1];
      present[i]   = present[i-1];
    end
    flux_hist[0] = b.sample_ok ? b.sample : '0;
    present[0]   = b.sample_ok;
    if (b.sample_ok) begin
      six_sum = six_sum + b.sample;
      day_sum = day_sum + b.sample;
      cnt6++;
      cnt24++;
    end
    v6  = cnt6 > min6;
    v24 = cnt24 > min24;
    r.short_valid = v6;
    r.short_index = v6 ? depth_from_flux(six_sum, cap6) : '0;
    r.long_valid  = v24;
    r.long_index  = v24 ? depth_from_flux(day_sum, cap24) : '0;
    return r;
  endfunction

  task automatic flag(string what, int want, int got);
    $display("%0t mismatch on %s: expected %0d, got %0d", $time, what, want, got);
    mismatches++;
  endtask

  always @(posedge clk) begin
    out_beat_t want;
    if (rst) begin
      gain_q16    = GAIN_RST;
      flux_offset = OFFSET_RST;
      cap6        = CAP_SHORT_RST;
      cap24       = CAP_LONG_RST;
      min6        = MINS_RST;
      min24       = MINL_RST;
      for (int i = 0; i < LONG_SAMPLES; i++) begin
        flux_hist[i] = '0;
        present[i]   = 1'b0;
      end
      six_sum    = '0;
      day_sum    = '0;
      cnt6       = 0;
      cnt24      = 0;
      mismatches = 0;
      depth_q.delete();
      pending <= 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_DRIFT_GAIN:      gain_q16    = cfg_data[GAIN_W-1:0];
          REG_DRIFT_OFFSET:    flux_offset = cfg_data[OFFSET_W-1:0];
          REG_CAP_SHORT:       cap6        = cfg_data[CAP_W-1:0];
          REG_CAP_LONG:        cap24       = cfg_data[CAP_W-1:0];
          REG_MIN_COUNT_SHORT: min6        = cfg_data[MINS_W-1:0];
          REG_MIN_COUNT_LONG:  min24       = cfg_data[MINL_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (depth_q.size() == 0) begin
          $display("%0t unexpected output beat: %0d/%0d %0d/%0d", $time,
                   out_data.short_index, out_data.short_valid,
                   out_data.long_index, out_data.long_valid);
          mismatches++;
        end else begin
          want = depth_q.pop_front();
          if (out_data.short_index !== want.short_index)
            flag("short_index", want.short_index, out_data.short_index);
          if (out_data.short_valid !== want.short_valid)
            flag("short_valid", want.short_valid, out_data.short_valid);
          if (out_data.long_index !== want.long_index)
            flag("long_index", want.long_index, out_data.long_index);
          if (out_data.long_valid !== want.long_valid)
            flag("long_valid", want.long_valid, out_data.long_valid);
        end
      end
      if (in_valid && !in_stall)
        depth_q.push_back(advance_window(in_data));
      pending <= depth_q.size();
    end
  end

endmodule

[tb/sv/tb_windowed_drift_index.sv]
`timescale 1ns / 100ps
// Top of the windowed drift index testbench: clock, reset, register loads,
// sample stimulus with random gaps and output stalls, watchdog and verdict.
// Depends on wdi_pkg, wdi_checker and the windowed_drift_index RTL.

module tb_windowed_drift_index;
  import wdi_pkg::*;

  // Cycles without any accepted beat before the run is declared hung
  localparam int HANG_LIMIT = 3000;
  localparam int PHASES     = 8;
  localparam int PHASE_BEATS = 250;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_stall;
  in_beat_t              in_data;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_beat_t             out_data;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int   pending;
  int   mismatches;
  int   quiet_cycles = 0;
  // When set, neither side idles: back to back beats at full rate
  logic steady = 1'b0;

  windowed_drift_index dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  wdi_checker scoreboard (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pending    (pending),
    .mismatches (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stall the output with a chance of roughly 28 percent, never while steady
  always @(posedge clk)
    out_stall <= steady ? 1'b0 : ($urandom_range(0, 99) < 28);

  // Watchdog: count cycles in which no beat moves on either channel
  always @(posedge clk) begin
    if (rst || cfg_write || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= HANG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic in_beat_t beat_of(logic [SAMPLE_W-1:0] value, logic ok);
    in_beat_t b;
    b.sample    = value;
    b.sample_ok = ok;
    return b;
  endfunction

  // Mix of sample sizes: small sums stay below the caps, large ones saturate,
  // the full range exercises every bit and the sign.
  function automatic in_beat_t random_beat(int ok_pct);
    logic [SAMPLE_W-1:0] value;
    case ($urandom_range(0, 5))
      0: value = SAMPLE_W'($urandom);
      1: value = SAMPLE_W'($urandom_range(0, 40));
      2: value = SAMPLE_W'($urandom_range(0, 4000));
      3: value = SAMPLE_W'($urandom_range(0, 80)) - SAMPLE_W'(40);
      4: value = $urandom_range(0, 1) ? 24'h7F_FFFF : 24'h80_0000;
      default: value = SAMPLE_W'($urandom_range(1000000, 8388607));
    endcase
    return beat_of(value, $urandom_range(0, 99) < ok_pct);
  endfunction

  // Offer one beat, idling first at random; return once it has been taken.
  // Valid stays high after the accepting edge so beats can run back to back.
  task automatic send_beat(in_beat_t b);
    while (!steady && $urandom_range(0, 99) < 28) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid and hold until every predicted beat has come out
  task automatic drain;
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic poke(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  task automatic load_registers(logic [GAIN_W-1:0] gain, int offset, int cap6, int cap24,
                                int min6, int min24);
    poke(REG_DRIFT_GAIN, gain);
    poke(REG_DRIFT_OFFSET, CFG_DATA_W'(offset));
    poke(REG_CAP_SHORT, CFG_DATA_W'(cap6));
    poke(REG_CAP_LONG, CFG_DATA_W'(cap24));
    poke(REG_MIN_COUNT_SHORT, CFG_DATA_W'(min6));
    poke(REG_MIN_COUNT_LONG, CFG_DATA_W'(min24));
    cfg_write <= 1'b0;
  endtask

  initial begin
    int ok_pct;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_write <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed beats on the reset register values. Start with the sample
    // extremes and a missing sample carrying a large value, which must not
    // reach the sums.
    send_beat(beat_of(24'h7F_FFFF, 1'b1));
    send_beat(beat_of(24'h80_0000, 1'b1));
    send_beat(beat_of(24'h7F_FFFF, 1'b0));
    send_beat(beat_of(24'h00_0000, 1'b1));
    // Fill the six hour window with the largest sample: its index hits the
    // cap while the day window stays below its threshold
    repeat (12) send_beat(beat_of(24'h7F_FFFF, 1'b1));
    // Pull the sums down with the most negative sample
    repeat (4) send_beat(beat_of(24'h80_0000, 1'b1));
    // Run of missing samples: counts fall as old samples leave
    repeat (4) send_beat(beat_of(24'h00_0005, 1'b0));

    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        // No gain, lowest offset, widest caps, every window valid
        0: load_registers(32'd0, -8388608, 65535, 65535, 0, 0);
        // Largest gain and offset; thresholds at the window sizes so
        // neither index is ever valid
        1: load_registers(32'hFFFF_FFFF, 8388607, 65535, 65535, 12, 48);
        // Unity gain, moderate thresholds
        2: load_registers(32'h0001_0000, 0, 7680, 30720, 3, 20);
        // Largest gain with both caps at zero
        3: load_registers(32'hFFFF_FFFF, -8388608, 0, 0, 0, 0);
        // Back to the reset values
        4: load_registers(GAIN_RST, 0, CAP_SHORT_RST, CAP_LONG_RST, MINS_RST, MINL_RST);
        default:
          load_registers($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1 << 22),
                         $urandom_range(0, 1) ? int'($urandom_range(0, 8000)) - 4000
                                              : int'($signed(SAMPLE_W'($urandom))),
                         $urandom_range(0, 65535), $urandom_range(0, 65535),
                         $urandom_range(0, 12), $urandom_range(0, 48));
      endcase
      // One phase runs at full rate on both sides
      steady <= (p == 2);
      case ($urandom_range(0, 3))
        0: ok_pct = 100;
        1: ok_pct = 90;
        2: ok_pct = 75;
        default: ok_pct = 50;
      endcase
      repeat (PHASE_BEATS) send_beat(random_beat(ok_pct));
    end

    drain();
    steady <= 1'b0;
    // Allow the pipeline depth for any stray beat to show up
    repeat (8) @(posedge clk);
    if (mismatches == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule
